// ===== rtl/cbz_pkg.sv =====
`timescale 1ns / 1ps
// cbz_pkg: shared types, widths and helper functions for the bezier easing solver
// depends on nothing; imported by cbz_ctrl, cbz_datapath and the top level

package cbz_pkg;

    // fixed-point layout: t is unsigned Q1.16, coordinates signed Q2.16
    localparam int FRAC_BITS = 16;
    localparam int T_W       = FRAC_BITS + 1;
    localparam int COORD_W   = 18;
    localparam int OPB_W     = 20;
    localparam int PROD_W    = T_W + 1 + OPB_W;
    localparam int ACC_W     = 42;
    localparam int RND_W     = ACC_W - FRAC_BITS;
    localparam int DIFF_W    = 21;
    localparam int DEN_W     = 21;
    localparam int DIV_N     = DIFF_W + FRAC_BITS;
    localparam int DIVC_W    = $clog2(DIV_N);

    // newton loop bound and evaluation schedule
    localparam int NEWTON_LIMIT = 10;
    localparam int ITER_W    = $clog2(NEWTON_LIMIT + 1);
    localparam int STEP_W    = 4;
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(14);

    localparam logic [T_W-1:0] T_ONE = T_W'(1 << FRAC_BITS);

    // configuration register indexes
    localparam logic [2:0] REG_START_X = 3'd0;
    localparam logic [2:0] REG_END_Y   = 3'd7;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL_X,
        S_CHECK,
        S_DIV,
        S_UPDATE,
        S_FIN_X,
        S_FIN_Y,
        S_DONE
    } t_state;

    typedef struct packed {
        logic              load_item;
        logic              eval_en;
        logic [STEP_W-1:0] step;
        logic              sel_y;
        logic              div_load;
        logic              div_step;
        logic              update_t;
        logic              save_sx;
        logic              load_out;
    } t_cmd;

    typedef struct packed {
        logic chk_exit;
        logic delta_zero;
    } t_status;

    // round half up from Q(16+F) to Q.16 (floor shift)
    function automatic logic signed [RND_W-1:0] rnd_q16(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] s;
        begin
            s = v + ACC_W'(1 << (FRAC_BITS - 1));
            rnd_q16 = s[ACC_W-1:FRAC_BITS];
        end
    endfunction

    // saturate to signed Q2.16 range
    function automatic logic [COORD_W-1:0] sat_point(input logic signed [RND_W-1:0] v);
        begin
            if (v < -RND_W'(131072)) begin
                sat_point = COORD_W'(-131072);
            end else if (v > RND_W'(131071)) begin
                sat_point = COORD_W'(131071);
            end else begin
                sat_point = v[COORD_W-1:0];
            end
        end
    endfunction

    // saturate to the slope range of the outputs
    function automatic logic [20:0] sat_slope(input logic signed [RND_W-1:0] v);
        begin
            if (v < -RND_W'(786432)) begin
                sat_slope = 21'(-786432);
            end else if (v > RND_W'(786431)) begin
                sat_slope = 21'(786431);
            end else begin
                sat_slope = v[20:0];
            end
        end
    endfunction

endpackage

// ===== rtl/cbz_ctrl.sv =====
`timescale 1ns / 1ps
// cbz_ctrl: sequencer for newton iterations, division and final evaluation
// depends on cbz_pkg; drives the datapath through t_cmd

module cbz_ctrl import cbz_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_stall,
    output logic    o_valid,
    input  logic    i_stall,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state              r_state, n_state;
    logic [STEP_W-1:0]   r_step, n_step;
    logic [DIVC_W-1:0]   r_divc, n_divc;
    logic [ITER_W-1:0]   r_iter, n_iter;
    logic                r_out_valid, n_out_valid;
    logic                out_free;
    logic                step_last;

    assign out_free  = !r_out_valid || !i_stall;
    assign step_last = (r_step == LAST_STEP);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_valid) n_state = S_EVAL_X;
            S_EVAL_X: if (step_last) n_state = S_CHECK;
            S_CHECK: begin
                n_state = i_status.chk_exit ? S_FIN_X : S_DIV;
            end
            S_DIV:    if (r_divc == DIVC_W'(DIV_N - 1)) n_state = S_UPDATE;
            S_UPDATE: begin
                if (i_status.delta_zero || r_iter == ITER_W'(NEWTON_LIMIT - 1)) begin
                    n_state = S_FIN_X;
                end else begin
                    n_state = S_EVAL_X;
                end
            end
            S_FIN_X:  if (step_last) n_state = S_FIN_Y;
            S_FIN_Y:  if (step_last) n_state = S_DONE;
            S_DONE:   if (out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // step, division and iteration counters, output word flag
    always_comb begin
        n_step = '0;
        if (r_state == S_EVAL_X || r_state == S_FIN_X || r_state == S_FIN_Y) begin
            n_step = step_last ? '0 : r_step + 1'b1;
        end
        n_divc = (r_state == S_DIV) ? r_divc + 1'b1 : '0;
        n_iter = r_iter;
        if (r_state == S_IDLE) begin
            n_iter = '0;
        end else if (r_state == S_UPDATE) begin
            n_iter = r_iter + 1'b1;
        end
        n_out_valid = (r_state == S_DONE && out_free) ? 1'b1 : (r_out_valid && i_stall);
    end

    // commands
    always_comb begin
        o_cmd           = '0;
        o_cmd.step      = r_step;
        o_cmd.load_item = (r_state == S_IDLE) && i_valid;
        o_cmd.eval_en   = (r_state == S_EVAL_X) || (r_state == S_FIN_X) ||
                          (r_state == S_FIN_Y);
        o_cmd.sel_y     = (r_state == S_FIN_Y);
        o_cmd.div_load  = (r_state == S_CHECK);
        o_cmd.div_step  = (r_state == S_DIV);
        o_cmd.update_t  = (r_state == S_UPDATE);
        o_cmd.save_sx   = (r_state == S_FIN_Y) && (r_step == '0);
        o_cmd.load_out  = (r_state == S_DONE) && out_free;
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_divc      <= '0;
            r_iter      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_divc      <= n_divc;
            r_iter      <= n_iter;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ===== rtl/cbz_datapath.sv =====
`timescale 1ns / 1ps
// cbz_datapath: control point registers, shared multiplier, accumulators,
// restoring divider and result registers; depends on cbz_pkg

module cbz_datapath import cbz_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    input  logic [2:0]          i_cfg_index,
    input  logic [COORD_W-1:0]  i_cfg_data,
    input  logic [COORD_W-1:0]  i_progress_x,
    input  t_cmd                i_cmd,
    output t_status             o_status,
    output logic [T_W-1:0]      o_solved_t,
    output logic [COORD_W-1:0]  o_eased_y,
    output logic [20:0]         o_slope_x,
    output logic [20:0]         o_slope_y
);

    logic signed [COORD_W-1:0] r_px [4];
    logic signed [COORD_W-1:0] r_py [4];

    logic [T_W-1:0]            r_t, r_target;
    logic [T_W-1:0]            r_u2, r_t2, r_ut, r_w0, r_w1, r_w2, r_w3;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [ACC_W-1:0]   r_acc, r_dacc;
    logic [DEN_W-1:0]          r_rem, r_den;
    logic [DIV_N-1:0]          r_quo;
    logic                      r_neg;
    logic [20:0]               r_sx;
    logic [T_W-1:0]            r_out_t;
    logic [COORD_W-1:0]        r_out_y;
    logic [20:0]               r_out_sx, r_out_sy;

    logic [T_W-1:0]            target_c, u, op_a, rnd_t;
    logic signed [OPB_W-1:0]   op_b, c0, c1, c2, c3;
    logic signed [PROD_W-1:0]  prod_c, prod_rnd;
    logic signed [ACC_W-1:0]   p1x, p3x, p6x;
    logic [STEP_W-1:0]         cons;
    logic signed [RND_W-1:0]   xt, dr;
    logic signed [DIFF_W-1:0]  diff;
    logic signed [DEN_W:0]     d;
    logic [DIFF_W-1:0]         diff_mag;
    logic [DEN_W:0]            shifted, trial;
    logic signed [DIV_N+1:0]   delta, t_new;
    logic [ACC_W-FRAC_BITS-1:0] dhi;

    // target clamp to 0..1.0
    always_comb begin
        if (i_progress_x[COORD_W-1]) begin
            target_c = '0;
        end else if (i_progress_x[COORD_W-2:0] > (COORD_W-1)'(T_ONE)) begin
            target_c = T_ONE;
        end else begin
            target_c = i_progress_x[T_W-1:0];
        end
    end

    // coordinate set in use
    always_comb begin
        if (i_cmd.sel_y) begin
            c0 = OPB_W'(r_py[0]); c1 = OPB_W'(r_py[1]);
            c2 = OPB_W'(r_py[2]); c3 = OPB_W'(r_py[3]);
        end else begin
            c0 = OPB_W'(r_px[0]); c1 = OPB_W'(r_px[1]);
            c2 = OPB_W'(r_px[2]); c3 = OPB_W'(r_px[3]);
        end
    end

    assign u = T_ONE - r_t;

    // operand select for the shared multiplier
    always_comb begin
        op_a = '0;
        op_b = '0;
        unique case (i_cmd.step)
            4'd0:    begin op_a = u;    op_b = OPB_W'(u);    end
            4'd1:    begin op_a = r_t;  op_b = OPB_W'(r_t);  end
            4'd2:    begin op_a = u;    op_b = OPB_W'(r_t);  end
            4'd3:    begin op_a = r_u2; op_b = OPB_W'(u);    end
            4'd4:    begin op_a = r_u2; op_b = OPB_W'(r_t);  end
            4'd5:    begin op_a = u;    op_b = OPB_W'(r_t2); end
            4'd6:    begin op_a = r_t2; op_b = OPB_W'(r_t);  end
            4'd7:    begin op_a = r_w0; op_b = c0;           end
            4'd8:    begin op_a = r_w1; op_b = c1;           end
            4'd9:    begin op_a = r_w2; op_b = c2;           end
            4'd10:   begin op_a = r_w3; op_b = c3;           end
            4'd11:   begin op_a = r_u2; op_b = c1 - c0;      end
            4'd12:   begin op_a = r_ut; op_b = c2 - c1;      end
            4'd13:   begin op_a = r_t2; op_b = c3 - c2;      end
            default: begin op_a = '0;   op_b = '0;           end
        endcase
    end

    assign prod_c   = $signed({1'b0, op_a}) * op_b;
    assign prod_rnd = r_prod + PROD_W'(1 << (FRAC_BITS - 1));
    assign rnd_t    = prod_rnd[FRAC_BITS+T_W-1:FRAC_BITS];
    assign p1x      = ACC_W'(r_prod);
    assign p3x      = p1x + (p1x <<< 1);
    assign p6x      = p3x <<< 1;
    assign cons     = i_cmd.step - 1'b1;

    // newton step status: flat derivative, quotient inputs
    assign dhi      = r_dacc[ACC_W-1:FRAC_BITS];
    assign dr       = rnd_q16(r_dacc);
    assign d        = dr[DEN_W:0];
    assign xt       = rnd_q16(r_acc);
    assign diff     = xt[DIFF_W-1:0] - DIFF_W'(r_target);
    assign diff_mag = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);

    assign o_status.chk_exit   = (dhi == '0) || (&dhi && r_dacc[FRAC_BITS-1:0] != '0) ||
                                 (d == '0);
    assign o_status.delta_zero = (r_quo == '0);

    // one restoring divider bit per cycle
    assign shifted = {r_rem, r_quo[DIV_N-1]};
    assign trial   = shifted - {1'b0, r_den};

    // t update with clamp to 0..1.0
    assign delta = r_neg ? -$signed({2'b00, r_quo}) : $signed({2'b00, r_quo});
    assign t_new = $signed((DIV_N+2)'(r_t)) - delta;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_px[0] <= '0; r_py[0] <= '0;
            r_px[1] <= '0; r_py[1] <= '0;
            r_px[2] <= COORD_W'(T_ONE); r_py[2] <= COORD_W'(T_ONE);
            r_px[3] <= COORD_W'(T_ONE); r_py[3] <= COORD_W'(T_ONE);
        end else if (i_cfg_valid && i_cfg_index >= REG_START_X &&
                     i_cfg_index <= REG_END_Y) begin
            if (i_cfg_index[0]) begin
                r_py[i_cfg_index[2:1]] <= i_cfg_data;
            end else begin
                r_px[i_cfg_index[2:1]] <= i_cfg_data;
            end
        end
    end

    // multiplier register and product consumers
    always_ff @(posedge i_clk) begin
        if (i_cmd.eval_en && i_cmd.step != LAST_STEP) begin
            r_prod <= prod_c;
        end
        if (i_cmd.eval_en && i_cmd.step != '0) begin
            unique case (cons)
                4'd0:    r_u2   <= rnd_t;
                4'd1:    r_t2   <= rnd_t;
                4'd2:    r_ut   <= rnd_t;
                4'd3:    r_w0   <= rnd_t;
                4'd4:    r_w1   <= rnd_t;
                4'd5:    r_w2   <= rnd_t;
                4'd6:    r_w3   <= rnd_t;
                4'd7:    r_acc  <= p1x;
                4'd8:    r_acc  <= r_acc + p3x;
                4'd9:    r_acc  <= r_acc + p3x;
                4'd10:   r_acc  <= r_acc + p1x;
                4'd11:   r_dacc <= p3x;
                4'd12:   r_dacc <= r_dacc + p6x;
                4'd13:   r_dacc <= r_dacc + p3x;
                default: r_acc  <= r_acc;
            endcase
        end
    end

    // item load, divider and t update
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_target <= target_c;
            r_t      <= target_c;
        end else if (i_cmd.update_t) begin
            if (t_new < 0) begin
                r_t <= '0;
            end else if (t_new > $signed((DIV_N+2)'(T_ONE))) begin
                r_t <= T_ONE;
            end else begin
                r_t <= t_new[T_W-1:0];
            end
        end
        if (i_cmd.div_load) begin
            r_rem <= '0;
            r_quo <= {diff_mag, FRAC_BITS'(0)};
            r_den <= d[DEN_W] ? DEN_W'(-d) : DEN_W'(d);
            r_neg <= diff[DIFF_W-1] ^ d[DEN_W];
        end else if (i_cmd.div_step) begin
            if (!trial[DEN_W]) begin
                r_rem <= trial[DEN_W-1:0];
            end else begin
                r_rem <= shifted[DEN_W-1:0];
            end
            r_quo <= {r_quo[DIV_N-2:0], !trial[DEN_W]};
        end
    end

    // result word
    always_ff @(posedge i_clk) begin
        if (i_cmd.save_sx) begin
            r_sx <= sat_slope(dr);
        end
        if (i_cmd.load_out) begin
            r_out_t  <= r_t;
            r_out_y  <= sat_point(xt);
            r_out_sx <= r_sx;
            r_out_sy <= sat_slope(dr);
        end
    end

    assign o_solved_t = r_out_t;
    assign o_eased_y  = r_out_y;
    assign o_slope_x  = r_out_sx;
    assign o_slope_y  = r_out_sy;

endmodule

// ===== rtl/cubic_bezier_easing_solver_core.sv =====
`timescale 1ns / 1ps
// cubic_bezier_easing_solver_core: top level of the bezier easing solver
// depends on cbz_pkg, cbz_ctrl and cbz_datapath
//
// Usage
//   Input channel: i_valid / o_stall with i_progress_x (signed Q2.16). A word
//   is taken when i_valid is high and o_stall is low; o_stall is high while
//   an item is being solved or its result waits for the result register.
//   Output channel: o_valid / i_stall with o_solved_t, o_eased_y, o_slope_x,
//   o_slope_y. The result register holds its word while i_stall is high; a
//   new input word is taken meanwhile, and its result waits until the
//   register is free.
//   Configuration: i_cfg_valid / o_cfg_ready (always ready), i_cfg_index
//   selects one of the eight control point coordinates, i_cfg_data is the
//   value. Write only while the block is idle.
// Sequence
//   One item at a time. Each newton step evaluates the curve on the shared
//   multiplier, checks the slope, runs the restoring divider and updates t. Up
//   to 10 steps run, then x and y are evaluated at the final t and the result
//   is loaded; only then is the next input word taken.
// Reset
//   Synchronous, active low: control points return to (0,0) (0,0) (1,1)
//   (1,1), the sequencer goes idle and the result register is emptied.

module cubic_bezier_easing_solver_core import cbz_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [COORD_W-1:0]  i_progress_x,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [T_W-1:0]      o_solved_t,
    output logic [COORD_W-1:0]  o_eased_y,
    output logic [20:0]         o_slope_x,
    output logic [20:0]         o_slope_y,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [2:0]          i_cfg_index,
    input  logic [COORD_W-1:0]  i_cfg_data
);

    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = 1'b1;

    // sequencer
    cbz_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .i_status (status),
        .o_cmd    (cmd)
    );

    // arithmetic
    cbz_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid && o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_progress_x (i_progress_x),
        .i_cmd        (cmd),
        .o_status     (status),
        .o_solved_t   (o_solved_t),
        .o_eased_y    (o_eased_y),
        .o_slope_x    (o_slope_x),
        .o_slope_y    (o_slope_y)
    );

    // solved t never leaves 0..1.0
    a_t_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_solved_t <= T_ONE)
        else $error("solved t out of range");

    // slope outputs stay above the lower saturation limit
    a_slope_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($signed(o_slope_x) >= -21'sd786432 &&
                     $signed(o_slope_y) >= -21'sd786432))
        else $error("slope below saturation limit");

    // no evaluation, division step or t update runs while the input side is open
    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.eval_en || cmd.div_step || cmd.update_t) |-> o_stall)
        else $error("datapath busy while accepting input");

    // a loaded result always shows up as a valid output word
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |=> o_valid)
        else $error("result load lost");

endmodule
